>>> design/json_string_unescape_utf8_defines.svh
// Assertion macros for the checker file of the string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define JSU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/jsu_pkg.sv
// Shared types, character codes and helper functions of the string unescaper.
`default_nettype none
package jsu_pkg;

  // Width of the packed result bus on the output stream.
  localparam int unsigned TDATA_W = 40;
  // Widest code point after surrogate pairing.
  localparam int unsigned CP_W    = 21;

  // Characters with a meaning in the decoder.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Control bytes produced by the simple escapes.
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_TAB = 8'h09;

  // Surrogate ranges and the supplementary plane offset.
  localparam logic [15:0]     HI_SUR_FIRST = 16'hD800;
  localparam logic [15:0]     HI_SUR_LAST  = 16'hDBFF;
  localparam logic [15:0]     LO_SUR_FIRST = 16'hDC00;
  localparam logic [15:0]     LO_SUR_LAST  = 16'hDFFF;
  localparam logic [CP_W-1:0] SUPP_BASE    = 21'h10000;

  // UTF-8 lead and continuation markers.
  localparam logic [7:0] UTF_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF_CONT  = 8'h80;

  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_NO_OPEN      = 4'd1,
    ERR_BAD_ESCAPE   = 4'd2,
    ERR_BAD_HEX      = 4'd3,
    ERR_NO_BSLASH    = 4'd4,
    ERR_NO_U         = 4'd5,
    ERR_BAD_LOW      = 4'd6,
    ERR_STRAY_LOW    = 4'd7,
    ERR_CONTROL      = 4'd8,
    ERR_UNTERMINATED = 4'd9
  } err_code_t;

  typedef logic [3:0][7:0] byte_quad_t;

  // One decoded result as it leaves the decoder.
  typedef struct packed {
    logic [2:0] byte_count;
    byte_quad_t bytes;
    logic       done;
    err_code_t  err;
  } result_t;

  // Hex digit value with a valid flag in the top bit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/jsu_utf8_enc.sv
// UTF-8 encoder for one code point of up to 21 bits.
`default_nettype none
module jsu_utf8_enc (
  input  wire logic [jsu_pkg::CP_W-1:0] cp,
  output logic [2:0]                    byte_count,
  output jsu_pkg::byte_quad_t           bytes
);
  import jsu_pkg::*;

  // Pick the sequence length from the code point magnitude.
  always_comb begin
    bytes = '0;
    if (cp <= 21'h7F) begin
      byte_count = 3'd1;
      bytes[0]   = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      byte_count = 3'd2;
      bytes[0]   = UTF_LEAD2 | {3'b000, cp[10:6]};
      bytes[1]   = UTF_CONT | {2'b00, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      byte_count = 3'd3;
      bytes[0]   = UTF_LEAD3 | {4'b0000, cp[15:12]};
      bytes[1]   = UTF_CONT | {2'b00, cp[11:6]};
      bytes[2]   = UTF_CONT | {2'b00, cp[5:0]};
    end else begin
      byte_count = 3'd4;
      bytes[0]   = UTF_LEAD4 | {5'b00000, cp[20:18]};
      bytes[1]   = UTF_CONT | {2'b00, cp[17:12]};
      bytes[2]   = UTF_CONT | {2'b00, cp[11:6]};
      bytes[3]   = UTF_CONT | {2'b00, cp[5:0]};
    end
  end

endmodule
`default_nettype wire

>>> design/jsu_decode.sv
// Decoder state machine with its result register.
`default_nettype none
module jsu_decode (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic [7:0]   in_byte,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output jsu_pkg::result_t  out_result
);
  import jsu_pkg::*;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'd0,
    MODE_BODY  = 4'd1,
    MODE_ESC   = 4'd2,
    MODE_HEX1  = 4'd3,
    MODE_LOWBS = 4'd4,
    MODE_LOWU  = 4'd5,
    MODE_HEX2  = 4'd6
  } mode_t;

  mode_t       mode, mode_next;
  logic [1:0]  hex_cnt, hex_cnt_next;
  logic [15:0] code_accum, code_accum_next;
  logic [9:0]  high_bits, high_bits_next;
  result_t     res_next;

  logic [4:0]       hv;
  logic [15:0]      accum_shift;
  logic [CP_W-1:0]  enc_cp;
  logic [2:0]       enc_count;
  byte_quad_t       enc_bytes;

  // The result register advances when it is empty or being drained.
  assign in_ready = !out_valid || out_ready;

  assign hv          = hex_value(in_byte);
  assign accum_shift = {code_accum[11:0], hv[3:0]};

  // Code point for the encoder: a plain escape, or a surrogate pair.
  always_comb begin
    if (mode == MODE_HEX2) begin
      enc_cp = SUPP_BASE + {1'b0, high_bits, accum_shift[9:0]};
    end else begin
      enc_cp = {5'b00000, accum_shift};
    end
  end

  jsu_utf8_enc u_enc (
    .cp         (enc_cp),
    .byte_count (enc_count),
    .bytes      (enc_bytes)
  );

  // Next state and result for the byte at the input.
  always_comb begin
    mode_next       = mode;
    hex_cnt_next    = hex_cnt;
    code_accum_next = code_accum;
    high_bits_next  = high_bits;
    res_next        = '0;
    res_next.err    = ERR_NONE;
    case (mode)
      MODE_BODY: begin
        if (in_byte == CH_QUOTE) begin
          res_next.done = 1'b1;
          mode_next     = MODE_IDLE;
        end else if (in_byte == CH_BSLASH) begin
          mode_next = MODE_ESC;
        end else if (in_byte == CH_NUL) begin
          res_next.err = ERR_UNTERMINATED;
        end else if (in_byte < CH_SPACE) begin
          res_next.err = ERR_CONTROL;
        end else begin
          res_next.bytes[0]   = in_byte;
          res_next.byte_count = 3'd1;
        end
      end
      MODE_ESC: begin
        mode_next           = MODE_BODY;
        res_next.byte_count = 3'd1;
        case (in_byte)
          CH_QUOTE, CH_BSLASH, CH_SLASH: res_next.bytes[0] = in_byte;
          CH_B: res_next.bytes[0] = CTL_BS;
          CH_F: res_next.bytes[0] = CTL_FF;
          CH_N: res_next.bytes[0] = CTL_LF;
          CH_R: res_next.bytes[0] = CTL_CR;
          CH_T: res_next.bytes[0] = CTL_TAB;
          CH_U: begin
            res_next.byte_count = 3'd0;
            mode_next           = MODE_HEX1;
            hex_cnt_next        = 2'd0;
            code_accum_next     = 16'd0;
          end
          default: res_next.err = ERR_BAD_ESCAPE;
        endcase
      end
      MODE_HEX1, MODE_HEX2: begin
        if (!hv[4]) begin
          res_next.err = ERR_BAD_HEX;
        end else begin
          code_accum_next = accum_shift;
          if (hex_cnt != 2'd3) begin
            hex_cnt_next = hex_cnt + 2'd1;
          end else begin
            hex_cnt_next = 2'd0;
            if (mode == MODE_HEX1) begin
              if (accum_shift >= HI_SUR_FIRST && accum_shift <= HI_SUR_LAST) begin
                high_bits_next = accum_shift[9:0];
                mode_next      = MODE_LOWBS;
              end else if (accum_shift >= LO_SUR_FIRST && accum_shift <= LO_SUR_LAST) begin
                res_next.err = ERR_STRAY_LOW;
              end else begin
                res_next.byte_count = enc_count;
                res_next.bytes      = enc_bytes;
                mode_next           = MODE_BODY;
              end
            end else begin
              if (accum_shift < LO_SUR_FIRST || accum_shift > LO_SUR_LAST) begin
                res_next.err = ERR_BAD_LOW;
              end else begin
                res_next.byte_count = enc_count;
                res_next.bytes      = enc_bytes;
                mode_next           = MODE_BODY;
              end
            end
          end
        end
      end
      MODE_LOWBS: begin
        if (in_byte == CH_BSLASH) begin
          mode_next = MODE_LOWU;
        end else begin
          res_next.err = ERR_NO_BSLASH;
        end
      end
      MODE_LOWU: begin
        if (in_byte == CH_U) begin
          mode_next       = MODE_HEX2;
          hex_cnt_next    = 2'd0;
          code_accum_next = 16'd0;
        end else begin
          res_next.err = ERR_NO_U;
        end
      end
      default: begin
        // Waiting for an opening quote; unused codes behave the same.
        if (in_byte == CH_QUOTE) begin
          mode_next = MODE_BODY;
        end else begin
          res_next.err = ERR_NO_OPEN;
        end
      end
    endcase

    // Any error drops the output and returns to waiting.
    if (res_next.err != ERR_NONE) begin
      mode_next           = MODE_IDLE;
      hex_cnt_next        = 2'd0;
      res_next.byte_count = 3'd0;
      res_next.bytes      = '0;
      res_next.done       = 1'b0;
    end
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      hex_cnt    <= 2'd0;
      code_accum <= 16'd0;
      high_bits  <= 10'd0;
      out_valid  <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
      if (in_valid) begin
        mode       <= mode_next;
        hex_cnt    <= hex_cnt_next;
        code_accum <= code_accum_next;
        high_bits  <= high_bits_next;
        out_result <= res_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
//
//   Channel | Direction | Transaction
//   s_      | in        | one byte of the string literal
//   m_      | out       | up to four UTF-8 bytes, end-of-string, error code
//
// Every accepted byte gives exactly one result, which passes an input register
// and then a result register.
// A new byte is taken every cycle while the output side takes the results.
// Reset returns the decoder to waiting for an opening quote and empties both
// registers. A stalled output holds its result; the input register takes one
// more byte only if it is empty, and then s_tready drops.
`default_nettype none
module json_string_unescape_utf8 (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,  // [7:0] char_byte
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [2:0] byte_count, [10:3] out_byte0, [18:11] out_byte1,
  // [26:19] out_byte2, [34:27] out_byte3, [39:35] zero
  output logic [jsu_pkg::TDATA_W-1:0]        m_tdata,
  output logic                               m_tlast,  // string_done
  output logic [3:0]                         m_tuser   // [3:0] error_code
);
  import jsu_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       dec_ready;
  result_t    result;

  // Input register: refills whenever the decoder takes its byte.
  assign s_tready = !in_valid || dec_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
      if (s_tvalid) begin
        in_byte <= s_tdata;
      end
    end
  end

  jsu_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .in_ready   (dec_ready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  // Pack the result onto the output stream.
  assign m_tdata = {5'b00000, result.bytes[3], result.bytes[2], result.bytes[1],
                    result.bytes[0], result.byte_count};
  assign m_tlast = result.done;
  assign m_tuser = result.err;

endmodule
`default_nettype wire

>>> design/jsu_checker.sv
// Port-level checker for the string unescaper and its bind.
`default_nettype none
`include "json_string_unescape_utf8_defines.svh"
module jsu_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [jsu_pkg::TDATA_W-1:0]   m_tdata,
  input wire logic                          m_tlast,
  input wire logic [3:0]                    m_tuser
);
  import jsu_pkg::*;

  // An error result carries no bytes and never ends a string.
  `JSU_ASSERT_SAME(a_err_empty, clk, rst, m_tvalid && m_tuser != ERR_NONE, m_tdata[2:0] == 3'd0 && !m_tlast, "error result carries data")
  // The byte count never exceeds four.
  `JSU_ASSERT_SAME(a_count_range, clk, rst, m_tvalid, m_tdata[2:0] <= 3'd4, "byte count above four")
  // A closing quote produces no bytes.
  `JSU_ASSERT_SAME(a_done_empty, clk, rst, m_tvalid && m_tlast, m_tdata[2:0] == 3'd0, "closing quote carries bytes")
  // Bytes beyond a single-byte result are zero.
  `JSU_ASSERT_SAME(a_single_zero, clk, rst, m_tvalid && m_tdata[2:0] == 3'd1, m_tdata[34:11] == 24'd0, "stale bytes after first")
  // A stalled result holds.
  `JSU_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  // Cycles with no transaction on either side before the run is abandoned.
  localparam int unsigned STALL_LIMIT = 1000;
  // Pending bytes below which neither side starts a new idle burst.
  localparam int unsigned TAIL_ITEMS  = 100;
  localparam int unsigned RANDOM_ITEMS = 800;

  // Second bytes of the two-byte escapes.
  localparam logic [7:0] SIMPLE_ESC [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                            CH_F, CH_N, CH_R, CH_T};
  // Code points on the borders of the UTF-8 length classes and the surrogates.
  localparam logic [15:0] BMP_EDGES [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                            16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};

  // Decoder states as the predictor tracks them.
  typedef enum logic [3:0] {
    MODE_WAIT       = 4'd0,
    MODE_BODY       = 4'd1,
    MODE_ESC        = 4'd2,
    MODE_HEX_FIRST  = 4'd3,
    MODE_LOW_BSLASH = 4'd4,
    MODE_LOW_U      = 4'd5,
    MODE_HEX_SECOND = 4'd6
  } decode_mode_t;

  // One byte waiting to be sent; drain holds it back until all results are in.
  typedef struct {
    logic [7:0] ch;
    bit         drain;
  } stim_byte_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'h00;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;
  logic                 m_tlast;
  logic [3:0]           m_tuser;

  stim_byte_t   pending[$];
  result_t      results_due[$];
  int unsigned  mismatches = 0;
  int unsigned  results_seen = 0;
  int unsigned  stall_cycles = 0;
  bit           byte_taken = 1'b0;
  int           tx_gap = 0;
  int           tx_calm = 0;
  int           rx_gap = 0;
  int           rx_calm = 0;

  // Predictor state.
  decode_mode_t mode = MODE_WAIT;
  logic [1:0]   hex_count = 2'd0;
  logic [15:0]  accum = 16'h0000;
  logic [9:0]   hi_bits = 10'h000;

  json_string_unescape_utf8 DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hex digit value with a valid flag in the top bit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
    if (ch >= 8'h30 && ch <= 8'h39) return {1'b1, ch[3:0]};
    if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
      return {1'b1, ch[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic result_t utf8_encode(input logic [20:0] cp);
    result_t r;
    r = '0;
    if (cp <= 21'h7F) begin
      r.byte_count = 3'd1;
      r.bytes[0]   = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      r.byte_count = 3'd2;
      r.bytes[0]   = UTF_LEAD2 | {3'b000, cp[10:6]};
      r.bytes[1]   = UTF_CONT | {2'b00, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      r.byte_count = 3'd3;
      r.bytes[0]   = UTF_LEAD3 | {4'b0000, cp[15:12]};
      r.bytes[1]   = UTF_CONT | {2'b00, cp[11:6]};
      r.bytes[2]   = UTF_CONT | {2'b00, cp[5:0]};
    end else begin
      r.byte_count = 3'd4;
      r.bytes[0]   = UTF_LEAD4 | {5'b00000, cp[20:18]};
      r.bytes[1]   = UTF_CONT | {2'b00, cp[17:12]};
      r.bytes[2]   = UTF_CONT | {2'b00, cp[11:6]};
      r.bytes[3]   = UTF_CONT | {2'b00, cp[5:0]};
    end
    return r;
  endfunction

  // Advances the predicted decoder by one input byte and returns its result.
  function automatic result_t decode_byte(input logic [7:0] ch);
    result_t    r;
    logic [4:0] nib;
    r = '0;
    r.err = ERR_NONE;
    case (mode)
      MODE_BODY: begin
        if (ch == CH_QUOTE) begin
          r.done = 1'b1;
          mode = MODE_WAIT;
        end else if (ch == CH_BSLASH) begin
          mode = MODE_ESC;
        end else if (ch == CH_NUL) begin
          r.err = ERR_UNTERMINATED;
        end else if (ch < CH_SPACE) begin
          r.err = ERR_CONTROL;
        end else begin
          r.byte_count = 3'd1;
          r.bytes[0] = ch;
        end
      end
      MODE_ESC: begin
        mode = MODE_BODY;
        r.byte_count = 3'd1;
        case (ch)
          CH_QUOTE, CH_BSLASH, CH_SLASH: r.bytes[0] = ch;
          CH_B: r.bytes[0] = CTL_BS;
          CH_F: r.bytes[0] = CTL_FF;
          CH_N: r.bytes[0] = CTL_LF;
          CH_R: r.bytes[0] = CTL_CR;
          CH_T: r.bytes[0] = CTL_TAB;
          CH_U: begin
            r.byte_count = 3'd0;
            mode = MODE_HEX_FIRST;
            hex_count = 2'd0;
            accum = 16'h0000;
          end
          default: r.err = ERR_BAD_ESCAPE;
        endcase
      end
      MODE_HEX_FIRST, MODE_HEX_SECOND: begin
        nib = hex_nibble(ch);
        if (!nib[4]) begin
          r.err = ERR_BAD_HEX;
        end else begin
          accum = {accum[11:0], nib[3:0]};
          if (hex_count != 2'd3) begin
            hex_count = hex_count + 2'd1;
          end else begin
            hex_count = 2'd0;
            if (mode == MODE_HEX_FIRST) begin
              if (accum >= HI_SUR_FIRST && accum <= HI_SUR_LAST) begin
                hi_bits = accum[9:0];
                mode = MODE_LOW_BSLASH;
              end else if (accum >= LO_SUR_FIRST && accum <= LO_SUR_LAST) begin
                r.err = ERR_STRAY_LOW;
              end else begin
                r = utf8_encode({5'd0, accum});
                mode = MODE_BODY;
              end
            end else if (accum < LO_SUR_FIRST || accum > LO_SUR_LAST) begin
              r.err = ERR_BAD_LOW;
            end else begin
              r = utf8_encode(SUPP_BASE + {1'b0, hi_bits, accum[9:0]});
              mode = MODE_BODY;
            end
          end
        end
      end
      MODE_LOW_BSLASH: begin
        if (ch == CH_BSLASH) mode = MODE_LOW_U;
        else r.err = ERR_NO_BSLASH;
      end
      MODE_LOW_U: begin
        if (ch == CH_U) begin
          mode = MODE_HEX_SECOND;
          hex_count = 2'd0;
          accum = 16'h0000;
        end else begin
          r.err = ERR_NO_U;
        end
      end
      default: begin
        if (ch == CH_QUOTE) mode = MODE_BODY;
        else r.err = ERR_NO_OPEN;
      end
    endcase
    // Any error drops the output and sends the decoder back to waiting.
    if (r.err != ERR_NONE) begin
      mode = MODE_WAIT;
      hex_count = 2'd0;
      r.byte_count = 3'd0;
      r.bytes = '0;
      r.done = 1'b0;
    end
    return r;
  endfunction

  // Random idle bursts, with calm stretches; no new bursts once the tail is reached.
  function automatic bit idle_now(inout int gap, inout int calm);
    if (gap != 0) begin
      gap--;
      return 1'b1;
    end
    if (pending.size() < TAIL_ITEMS) return 1'b0;
    if (calm != 0) begin
      calm--;
      return 1'b0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 120);
      return 1'b0;
    end
    if ($urandom_range(0, 5) == 0) begin
      gap = $urandom_range(0, 6);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%h, want 0x%h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  task automatic push(input logic [7:0] ch);
    stim_byte_t item;
    item.ch    = ch;
    item.drain = 1'b0;
    pending = {pending, item};
  endtask

  // Pushes a backslash-u escape, hex letters in random case.
  task automatic add_u_escape(input logic [15:0] v);
    logic [3:0] d;
    push(CH_BSLASH);
    push(CH_U);
    for (int k = 3; k >= 0; k--) begin
      d = v[4*k +: 4];
      if (d < 4'd10) push(8'h30 + d);
      else push(($urandom_range(0, 1) ? 8'h61 : 8'h41) + d - 8'd10);
    end
  endtask

  function automatic logic [7:0] printable_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(32, 255)); while (v == CH_QUOTE || v == CH_BSLASH);
    return v;
  endfunction

  // Any byte but the one given, zero often enough to hit the end-of-input cases.
  function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
    logic [7:0] v;
    if ($urandom_range(0, 3) == 0) return CH_NUL;
    do v = 8'($urandom_range(0, 255)); while (v == avoid);
    return v;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] v;
    if ($urandom_range(0, 3) == 0) return CH_NUL;
    do v = 8'($urandom_range(0, 255)); while (hex_nibble(v) != 5'd0);
    return v;
  endfunction

  function automatic logic [7:0] bad_escape_byte();
    logic [7:0] v;
    bit         known;
    if ($urandom_range(0, 3) == 0) return CH_NUL;
    do begin
      v = 8'($urandom_range(0, 255));
      known = (v == CH_U);
      foreach (SIMPLE_ESC[k]) if (v == SIMPLE_ESC[k]) known = 1'b1;
    end while (known);
    return v;
  endfunction

  // A code point of the basic plane that is not a surrogate.
  function automatic logic [15:0] bmp_value();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(16'h0000, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hD7FF));
      3: return 16'($urandom_range(16'hE000, 16'hFFFF));
      default: return BMP_EDGES[3'($urandom_range(0, 7))];
    endcase
  endfunction

  task automatic add_token();
    case ($urandom_range(0, 5))
      0, 1: push(printable_byte());
      2: begin
        push(CH_BSLASH);
        push(SIMPLE_ESC[3'($urandom_range(0, 7))]);
      end
      3, 4: add_u_escape(bmp_value());
      default: begin
        add_u_escape(16'($urandom_range(HI_SUR_FIRST, HI_SUR_LAST)));
        add_u_escape(16'($urandom_range(LO_SUR_FIRST, LO_SUR_LAST)));
      end
    endcase
  endtask

  // One string literal with random content; some carry a deliberate flaw.
  task automatic add_string();
    err_code_t   flaw;
    logic [15:0] v;
    flaw = ERR_NONE;
    if ($urandom_range(0, 3) == 0) flaw = err_code_t'($urandom_range(1, 9));
    if (flaw == ERR_NO_OPEN) repeat ($urandom_range(1, 3)) push(byte_other_than(CH_QUOTE));
    push(CH_QUOTE);
    pending[$].drain = ($urandom_range(0, 60) == 0);
    repeat ($urandom_range(0, 6)) add_token();
    case (flaw)
      ERR_BAD_ESCAPE: begin
        push(CH_BSLASH);
        push(bad_escape_byte());
      end
      ERR_BAD_HEX: begin
        if ($urandom_range(0, 1)) begin
          add_u_escape(16'($urandom_range(HI_SUR_FIRST, HI_SUR_LAST)));
        end
        push(CH_BSLASH);
        push(CH_U);
        repeat ($urandom_range(0, 3)) push(8'h30 + 8'($urandom_range(0, 9)));
        push(non_hex_byte());
      end
      ERR_NO_BSLASH: begin
        add_u_escape(16'($urandom_range(HI_SUR_FIRST, HI_SUR_LAST)));
        push(byte_other_than(CH_BSLASH));
      end
      ERR_NO_U: begin
        add_u_escape(16'($urandom_range(HI_SUR_FIRST, HI_SUR_LAST)));
        push(CH_BSLASH);
        push(byte_other_than(CH_U));
      end
      ERR_BAD_LOW: begin
        add_u_escape(16'($urandom_range(HI_SUR_FIRST, HI_SUR_LAST)));
        do v = 16'($urandom_range(0, 16'hFFFF)); while (v >= LO_SUR_FIRST && v <= LO_SUR_LAST);
        add_u_escape(v);
      end
      ERR_STRAY_LOW: add_u_escape(16'($urandom_range(LO_SUR_FIRST, LO_SUR_LAST)));
      ERR_CONTROL: push(8'($urandom_range(1, 31)));
      ERR_UNTERMINATED: push(CH_NUL);
      default: push(CH_QUOTE);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: one transaction per accepted byte, changes at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_bytes
    stim_byte_t item;
    logic       nxt_valid;
    logic [7:0] nxt_data;
    nxt_valid = s_tvalid;
    nxt_data  = s_tdata;
    if (rst) begin
      nxt_valid = 1'b0;
    end else if (!s_tvalid || byte_taken) begin
      nxt_valid = 1'b0;
      if (pending.size() != 0) begin
        if (!(pending[0].drain && results_due.size() != 0)) begin
          if (!idle_now(tx_gap, tx_calm)) begin
            item = pending.pop_front();
            nxt_valid = 1'b1;
            nxt_data  = item.ch;
          end
        end
      end
    end
    s_tvalid <= nxt_valid;
    s_tdata  <= nxt_data;
    if (rst) m_tready <= 1'b0;
    else m_tready <= !idle_now(rx_gap, rx_calm);
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on input transactions, checks output transactions
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    result_t want;
    bit      out_taken;
    byte_taken = !rst && s_tvalid && s_tready;
    out_taken  = !rst && m_tvalid && m_tready;
    if (byte_taken) results_due = {results_due, decode_byte(s_tdata)};
    if (out_taken) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, tdata 0x%h", m_tdata));
      end else begin
        want = results_due.pop_front();
        check_field("byte_count", {5'd0, m_tdata[2:0]}, {5'd0, want.byte_count});
        for (int k = 0; k < 4; k++)
          check_field($sformatf("out_byte%0d", k), m_tdata[3+8*k +: 8], want.bytes[k]);
        check_field("string_done", {7'd0, m_tlast}, {7'd0, want.done});
        check_field("error_code", {4'd0, m_tuser}, {4'd0, want.err});
      end
      results_seen++;
    end
    if (byte_taken || out_taken) stall_cycles = 0;
    else stall_cycles++;
  end

  initial begin : watchdog
    do @(negedge clk); while (stall_cycles < STALL_LIMIT);
    $display("json_string_unescape_utf8 regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int unsigned directed_len;
    // Directed: zero while waiting, escaped quote, the null escape, the largest
    // surrogate pair, a closing quote, and a raw control byte in a new string.
    push(CH_NUL);
    push(CH_QUOTE);
    push(CH_BSLASH);
    push(CH_QUOTE);
    add_u_escape(16'h0000);
    add_u_escape(HI_SUR_LAST);
    add_u_escape(LO_SUR_LAST);
    push(CH_QUOTE);
    push(CH_QUOTE);
    push(8'h1F);
    directed_len = pending.size();
    while (pending.size() < directed_len + RANDOM_ITEMS) add_string();
    // The random part starts only once the directed results are all in.
    pending[directed_len].drain = 1'b1;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do begin
      @(posedge clk);
      #1;
    end while (pending.size() != 0 || s_tvalid || results_due.size() != 0);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("json_string_unescape_utf8 regression: pass");
    end else begin
      $display("json_string_unescape_utf8 regression: fail");
    end
    $finish;
  end

endmodule
